/* sv/lotv_pkg.sv */
package lotv_pkg;

   // default table depth
   localparam int LOTV_MAX_VOLUMES = 16;

   // width of the slot / count fields carried down the chain (holds up to 511)
   localparam int TOK_IDX_W = 9;

   // request kinds
   typedef enum logic [1:0] {
      FN_APPEND    = 2'd0,
      FN_TRANSLATE = 2'd1,
      FN_CLEAR     = 2'd2,
      FN_NONE      = 2'd3
   } lotv_func_type;

   // response codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_FULL     = 2'd2,
      ST_OVERFLOW = 2'd3
   } lotv_status_type;

   // token handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  write;     // append: target cell loads wr_first / wr_end
      logic                  search;    // translate: cells look for the offset
      logic                  found;
      lotv_status_type       status;
      logic [3:0]            slot;
      logic [TOK_IDX_W-1:0]  target;    // append slot, or volume count for a search
      logic [31:0]           offset;
      logic [31:0]           req_pages;
      logic [31:0]           wr_first;
      logic [31:0]           wr_end;
      logic [31:0]           block;
      logic [31:0]           pages;
   } lotv_tok_type;

endpackage

/* sv/log_offset_to_volume_block_unit.sv */
// channel  | direction | tdata (low bit up)                                  | tuser
// ---------+-----------+-----------------------------------------------------+-------
// req      | in        | volume_pages, log_offset, page_count, zero fill     | func
// rsp      | out       | volume_slot, block_number, cluster_pages,           | status
//          |           | total_pages, zero fill                              |
//
// every transaction walks the row of MAX_VOLUMES entry cells, one cell a cycle, and the
// response register is loaded as the token leaves the row.
// one transaction is in the row at a time; a new request is taken once the previous
// one has left the row and the response register is free or being drained.
// reset (synchronous, active high) empties the table; entries need no clearing.
// a stalled response holds the next request off, nothing is dropped.
module log_offset_to_volume_block_unit #(
   parameter int MAX_VOLUMES = lotv_pkg::LOTV_MAX_VOLUMES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // volume_pages[31:0], log_offset[63:32],
                                     // page_count[95:64], zero[103:96]
   input  logic [1:0]   req_tuser,   // func[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // volume_slot[3:0], block_number[35:4],
                                     // cluster_pages[67:36], total_pages[99:68], zero
   output logic [1:0]   rsp_tuser    // status[1:0]
);
   import lotv_pkg::*;

   localparam int CNT_W = $clog2(MAX_VOLUMES + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]     total_ff, total_in;

   logic            rsp_valid_ff, rsp_valid_in;
   lotv_status_type rsp_status_ff, rsp_status_in;
   logic [3:0]      rsp_slot_ff, rsp_slot_in;
   logic [31:0]     rsp_block_ff, rsp_block_in;
   logic [31:0]     rsp_pages_ff, rsp_pages_in;
   logic [31:0]     rsp_total_ff, rsp_total_in;

   lotv_tok_type    tok [0:MAX_VOLUMES];
   lotv_tok_type    inj;
   lotv_tok_type    tail;

   lotv_func_type   func;
   logic [31:0]     vol_pages;
   logic [31:0]     log_offset;
   logic [31:0]     page_count;
   logic            req_xfer;
   logic [32:0]     app_sum;
   logic [32:0]     xl_end;
   logic            is_full;
   logic            out_of_range;

   // unpack request
   always_comb begin
      func       = lotv_func_type'(req_tuser);
      vol_pages  = req_tdata[31:0];
      log_offset = req_tdata[63:32];
      page_count = req_tdata[95:64];
   end

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;

   // bound checks for append and translate
   always_comb begin
      app_sum      = {1'b0, total_ff} + {1'b0, vol_pages};
      xl_end       = {1'b0, log_offset} + {1'b0, page_count};
      is_full      = (count_ff >= CNT_W'(MAX_VOLUMES));
      out_of_range = (log_offset >= total_ff) || (xl_end > {1'b0, total_ff});
   end

   // build the token entering the row and update count / total
   always_comb begin
      inj           = '0;
      inj.offset    = log_offset;
      inj.req_pages = page_count;
      inj.status    = ST_OK;
      count_in      = count_ff;
      total_in      = total_ff;
      if (req_xfer) begin
         inj.valid = 1'b1;
         unique case (func)
            FN_APPEND: begin
               if (is_full) begin
                  inj.status = ST_FULL;
               end else if (app_sum[32]) begin
                  inj.status = ST_OVERFLOW;
               end else begin
                  inj.write    = 1'b1;
                  inj.target   = TOK_IDX_W'(count_ff);
                  inj.slot     = 4'(count_ff);
                  inj.wr_first = total_ff;
                  inj.wr_end   = app_sum[31:0];
                  count_in     = count_ff + CNT_W'(1);
                  total_in     = app_sum[31:0];
               end
            end
            FN_TRANSLATE: begin
               if (out_of_range) begin
                  inj.status = ST_RANGE;
               end else begin
                  inj.search = 1'b1;
                  inj.target = TOK_IDX_W'(count_ff);
               end
            end
            FN_CLEAR: begin
               count_in = '0;
               total_in = '0;
            end
            default: begin
               inj.status = ST_OK;
            end
         endcase
      end
   end

   assign tok[0] = inj;

   // row of entry cells
   for (genvar i = 0; i < MAX_VOLUMES; i++) begin : g_cell
      lotv_cell #(
         .INDEX(i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_tok  (tok[i]),
         .down_tok(tok[i+1])
      );
   end

   assign tail = tok[MAX_VOLUMES];

   // sequencing
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (tail.valid) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register, loaded as the token leaves the row
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_total_in  = rsp_total_ff;
      if (tail.valid) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = total_ff;
         if (tail.search && !tail.found) begin
            rsp_status_in = ST_RANGE;
            rsp_slot_in   = '0;
            rsp_block_in  = '0;
            rsp_pages_in  = '0;
         end else begin
            rsp_status_in = tail.status;
            rsp_slot_in   = tail.slot;
            rsp_block_in  = tail.block;
            rsp_pages_in  = tail.pages;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0, rsp_total_ff, rsp_pages_ff, rsp_block_ff, rsp_slot_ff};

   // checks
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == S_RUN)
      else $error("accepted transaction did not start a walk");

   a_exit_only_in_run: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> state_ff == S_RUN)
      else $error("token left the row while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VOLUMES))
      else $error("volume count beyond table depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> !rsp_valid_ff || rsp_tready)
      else $error("response register overwritten while pending");

   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RUN))
      else $error("response appeared without a walk");

endmodule

/* sv/lotv_cell.sv */
module lotv_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lotv_pkg::lotv_tok_type up_tok,
   output lotv_pkg::lotv_tok_type down_tok
);
   import lotv_pkg::*;

   localparam logic [TOK_IDX_W-1:0] MY_IDX = TOK_IDX_W'(INDEX);

   logic [31:0]  first_ff, first_in;
   logic [31:0]  end_ff, end_in;
   lotv_tok_type tok_ff, tok_in;
   logic         wr;
   logic         hit;
   logic [31:0]  rel;
   logic [31:0]  remain;

   // volume entry load on append
   always_comb begin
      wr       = up_tok.valid && up_tok.write && (up_tok.target == MY_IDX);
      first_in = wr ? up_tok.wr_first : first_ff;
      end_in   = wr ? up_tok.wr_end : end_ff;
   end

   // lookup against this entry, first match wins
   always_comb begin
      rel    = up_tok.offset - first_ff;
      remain = end_ff - up_tok.offset;
      hit    = up_tok.valid && up_tok.search && !up_tok.found && (MY_IDX < up_tok.target)
               && (up_tok.offset >= first_ff) && (up_tok.offset < end_ff);
      tok_in = up_tok;
      if (hit) begin
         tok_in.found = 1'b1;
         tok_in.slot  = 4'(INDEX);
         tok_in.block = rel + 32'd1;
         tok_in.pages = (up_tok.req_pages < remain) ? up_tok.req_pages : remain;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      first_ff <= first_in;
      end_ff   <= end_in;
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

/* verif/volume_map_checker.sv */
module volume_map_checker #(
   parameter int MAX_VOLUMES = lotv_pkg::LOTV_MAX_VOLUMES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,   // volume_pages, log_offset, page_count, zero fill
   input  logic [1:0]   req_tuser,   // func
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,   // volume_slot, block_number, cluster_pages,
                                     // total_pages, zero fill
   input  logic [1:0]   rsp_tuser,   // status
   output int           fail_count,
   output int           results_pending
);
   import lotv_pkg::*;

   typedef struct {
      lotv_status_type status;
      logic [3:0]      slot;
      logic [31:0]     block;
      logic [31:0]     pages;
      logic [31:0]     total;
   } map_result_type;

   // shadow of the volume table
   logic [31:0] vol_first [MAX_VOLUMES];
   logic [31:0] vol_size  [MAX_VOLUMES];
   int          vol_count;
   logic [31:0] area_total;

   map_result_type expected_q [$];
   map_result_type want;
   map_result_type got;

   // work out the response of one request and update the shadow table
   function automatic map_result_type map_request(lotv_func_type fn, logic [31:0] vpages,
                                                  logic [31:0] offset, logic [31:0] pcount);
      map_result_type r;
      logic [31:0] rel;
      logic [31:0] room;
      bit          hit;
      int          i;
      r.status = ST_OK;
      r.slot   = '0;
      r.block  = '0;
      r.pages  = '0;
      case (fn)
         FN_APPEND: begin
            if (vol_count >= MAX_VOLUMES) begin
               r.status = ST_FULL;
            end else if ({1'b0, area_total} + {1'b0, vpages} > 33'h0_FFFF_FFFF) begin
               r.status = ST_OVERFLOW;
            end else begin
               vol_first[vol_count] = area_total;
               vol_size[vol_count]  = vpages;
               r.slot               = vol_count[3:0];
               vol_count++;
               area_total           = area_total + vpages;
            end
         end
         FN_TRANSLATE: begin
            // whole range must sit below the total, no wrap
            if (offset >= area_total ||
                {1'b0, offset} + {1'b0, pcount} > {1'b0, area_total}) begin
               r.status = ST_RANGE;
            end else begin
               hit = 1'b0;
               for (i = 0; i < vol_count; i++) begin
                  if (!hit && offset >= vol_first[i] && offset - vol_first[i] < vol_size[i]) begin
                     hit     = 1'b1;
                     rel     = offset - vol_first[i];
                     room    = vol_size[i] - rel;
                     r.slot  = i[3:0];
                     r.block = rel + 32'd1;
                     r.pages = (pcount < room) ? pcount : room;
                  end
               end
               if (!hit) r.status = ST_RANGE;
            end
         end
         FN_CLEAR: begin
            vol_count  = 0;
            area_total = '0;
         end
         default: ;
      endcase
      r.total = area_total;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] expected_val,
                                       logic [31:0] actual_val);
      if (actual_val !== expected_val) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name,
                  expected_val, actual_val);
         fail_count++;
      end
   endfunction

   // compare responses in order, then predict the request taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         vol_count  = 0;
         area_total = '0;
         fail_count = 0;
         expected_q.delete();
         results_pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = lotv_status_type'(rsp_tuser);
            got.slot   = rsp_tdata[3:0];
            got.block  = rsp_tdata[35:4];
            got.pages  = rsp_tdata[67:36];
            got.total  = rsp_tdata[99:68];
            if (expected_q.size() == 0) begin
               $display("%0t: response with nothing outstanding: expected none, actual %h/%h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", want.status, got.status);
               check_field("volume_slot", want.slot, got.slot);
               check_field("block_number", want.block, got.block);
               check_field("cluster_pages", want.pages, got.pages);
               check_field("total_pages", want.total, got.total);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_q.push_back(map_request(lotv_func_type'(req_tuser), req_tdata[31:0],
                                             req_tdata[63:32], req_tdata[95:64]));
         end
         results_pending <= expected_q.size();
      end
   end

endmodule

/* verif/tb_top.sv */
module tb_top;
   import lotv_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 950;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 2 * LOTV_MAX_VOLUMES + 8;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   int fail_count;
   int results_pending;
   int cycles       = 0;
   int stall_left   = 0;
   int items_sent   = 0;
   int func_tally [4];
   bit quiet_stretch = 1'b0;
   bit long_hold     = 1'b0;

   // rough picture of the volume layout, only to aim offsets at boundaries
   logic [31:0] layout_first [$];
   logic [31:0] layout_size  [$];
   logic [31:0] layout_total = '0;

   always #HALF_PERIOD clock = ~clock;

   log_offset_to_volume_block_unit #(
      .MAX_VOLUMES (LOTV_MAX_VOLUMES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   volume_map_checker #(
      .MAX_VOLUMES (LOTV_MAX_VOLUMES)
   ) map_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // response side backpressure, with one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold) begin
         rsp_tready <= 1'b0;
         stall_left = HOLD_CYCLES;
         long_hold  = 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = quiet_stretch ? 0 : pick_gap();
      end
   end

   // offer one request and wait for the transaction
   task automatic send_request(lotv_func_type fn, logic [31:0] vpages, logic [31:0] offset,
                               logic [31:0] pcount);
      int gap;
      gap = quiet_stretch ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {8'h00, pcount, offset, vpages};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      func_tally[fn]++;
      case (fn)
         FN_APPEND: begin
            if (layout_first.size() < LOTV_MAX_VOLUMES &&
                {1'b0, layout_total} + {1'b0, vpages} <= 33'h0_FFFF_FFFF) begin
               layout_first.push_back(layout_total);
               layout_size.push_back(vpages);
               layout_total = layout_total + vpages;
            end
         end
         FN_CLEAR: begin
            layout_first.delete();
            layout_size.delete();
            layout_total = '0;
         end
         default: ;
      endcase
   endtask

   initial begin
      int          roll;
      int          pick;
      int          k;
      int          target;
      bit          hold_done;
      bit          pause_done;
      logic [31:0] size;
      logic [31:0] offset;
      logic [31:0] pcount;

      hold_done  = 1'b0;
      pause_done = 1'b0;
      foreach (func_tally[i]) func_tally[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, unused code, empty volume, clipping, range edges
      send_request(FN_TRANSLATE, 32'd0, 32'd0, 32'd1);
      send_request(FN_CLEAR, 32'd0, 32'd0, 32'd0);
      send_request(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FN_APPEND, 32'd0, 32'd0, 32'd0);
      send_request(FN_APPEND, 32'd1, 32'd0, 32'd0);
      send_request(FN_APPEND, 32'd100, 32'd0, 32'd0);
      send_request(FN_TRANSLATE, 32'd0, 32'd0, 32'd101);
      send_request(FN_TRANSLATE, 32'd0, 32'd1, 32'd0);
      send_request(FN_TRANSLATE, 32'd0, 32'd50, 32'd51);
      send_request(FN_TRANSLATE, 32'd0, 32'd50, 32'd52);
      send_request(FN_TRANSLATE, 32'd0, 32'd101, 32'd1);
      send_request(FN_TRANSLATE, 32'd0, 32'd0, 32'hFFFF_FFFF);
      // total overflow, then fill the total to the top exactly
      send_request(FN_APPEND, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_request(FN_APPEND, 32'hFFFF_FFFF - 32'd101, 32'd0, 32'd0);
      send_request(FN_APPEND, 32'd1, 32'd0, 32'd0);
      send_request(FN_TRANSLATE, 32'd0, 32'hFFFF_FFFE, 32'd1);
      send_request(FN_TRANSLATE, 32'd0, 32'hFFFF_FFFF, 32'd1);
      send_request(FN_TRANSLATE, 32'd0, 32'd101, 32'hFFFF_FFFF - 32'd101);
      // fill the table, one more append finds it full
      for (k = 0; k <= LOTV_MAX_VOLUMES - 4; k++) begin
         send_request(FN_APPEND, 32'd0, 32'd0, 32'd0);
      end
      send_request(FN_CLEAR, 32'd0, 32'd0, 32'd0);
      send_request(FN_TRANSLATE, 32'd0, 32'd0, 32'd1);

      // random: mostly appends and translates aimed at the layout, some noise
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (!hold_done && items_sent >= 300) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && items_sent >= 500) begin
            pause_done = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (results_pending != 0) @(posedge clock);
         end
         quiet_stretch = (items_sent >= 620 && items_sent < 700);

         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            send_request(lotv_func_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
         end else if (roll < 12) begin
            send_request(FN_CLEAR, $urandom, $urandom, $urandom);
         end else if (roll < 42) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       size = '0;
            else if (pick < 48) size = $urandom_range(1, 16);
            else if (pick < 73) size = $urandom_range(1, 65535);
            else if (pick < 85) size = $urandom;
            else if (pick < 93) size = 32'hFFFF_FFFF - layout_total;
            else                size = 32'hFFFF_FFFF - layout_total + 32'd1;
            send_request(FN_APPEND, size, $urandom, $urandom);
         end else begin
            if (layout_total == 0) begin
               offset = $urandom_range(0, 1) ? 32'd0 : 32'($urandom);
            end else begin
               k = $urandom_range(0, layout_first.size() - 1);
               case ($urandom_range(0, 7))
                  0:       offset = layout_first[k];
                  1:       offset = layout_first[k] + layout_size[k] - 32'd1;
                  2:       offset = layout_total - 32'd1;
                  3:       offset = layout_total;
                  4:       offset = $urandom;
                  default: offset = 32'($urandom) % layout_total;
               endcase
            end
            case ($urandom_range(0, 7))
               0:       pcount = '0;
               1:       pcount = 32'd1;
               2:       pcount = layout_total - offset;
               3:       pcount = layout_total - offset + 32'd1;
               4:       pcount = $urandom;
               5:       pcount = 32'hFFFF_FFFF;
               default: pcount = $urandom_range(1, 64);
            endcase
            send_request(FN_TRANSLATE, $urandom, offset, pcount);
         end
      end
      quiet_stretch = 1'b0;

      // drain, then let the row empty out
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d transactions: %0d append, %0d translate, %0d clear, %0d unused",
               items_sent, func_tally[FN_APPEND], func_tally[FN_TRANSLATE],
               func_tally[FN_CLEAR], func_tally[FN_NONE]);
      $display("with table full, total overflow, range edges and a %0d-cycle response stall",
               HOLD_CYCLES);
      if (fail_count == 0 && results_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, results_pending);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
